FILE: rtl/sorted_value_list_top_macros.svh
// Assertion helpers shared by the RTL.
`ifndef SORTED_VALUE_LIST_TOP_MACROS_SVH
`define SORTED_VALUE_LIST_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge out of reset
`define SVL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be seen at a clock edge out of reset
`define SVL_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SVL_ASSERT(label, clk, rst_n, prop, msg)
`define SVL_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/svl_pkg.sv
package svl_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int OCC_W        = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // broadcast from control to every cell
  typedef struct packed {
    logic                     cmp;   // latch compare flags against key
    logic                     ins;   // insert key at first cell >= key
    logic                     del;   // close the gap at the first equal cell
    logic                     pop;   // shift whole row toward the head
    logic signed [DATA_W-1:0] key;
  } svl_bcast_t;

endpackage

FILE: rtl/svl_cell.sv
module svl_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  svl_pkg::svl_bcast_t              bc,
  input  logic signed [svl_pkg::DATA_W-1:0] left_val,
  input  logic                             left_valid,
  input  logic                             left_ge,
  input  logic signed [svl_pkg::DATA_W-1:0] right_val,
  input  logic                             right_valid,
  output logic signed [svl_pkg::DATA_W-1:0] val,
  output logic                             valid,
  output logic                             ge,
  output logic                             eq
);
  import svl_pkg::*;

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     valid_r, valid_nxt;
  logic                     ge_r, eq_r;

  // empty cells count as >= key so the insert point is local
  always_ff @(posedge clk) begin
    if (bc.cmp) begin
      ge_r <= !valid_r || (val_r >= bc.key);
      eq_r <= valid_r && (val_r == bc.key);
    end
  end

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (bc.ins && ge_r) begin
      if (!left_ge) begin
        val_nxt   = bc.key;
        valid_nxt = 1'b1;
      end else begin
        val_nxt   = left_val;
        valid_nxt = left_valid;
      end
    end else if (bc.pop || (bc.del && ge_r)) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign val   = val_r;
  assign valid = valid_r;
  assign ge    = ge_r;
  assign eq    = eq_r;

endmodule

FILE: rtl/sorted_value_list_top.sv
// Sorted value list: keeps up to CAPACITY signed 32-bit words in ascending order in a row of
// cells, one word per cell. A request is taken when start is high and busy is low; busy is high
// for the cycle after, while every cell compares its word with the operand, and at the end of
// the next cycle the cells that the operation moves shift at once. The result is shown for
// exactly one cycle on out_strobe, once the request has passed the cmp_r, apply_r and strobe_r
// registers. A new request can already be taken at the edge that puts the result out, while
// the last one is still in its shift step, whatever the operation. The receiver cannot stall:
// sample the result ports whenever out_strobe is high. No clearing pass follows reset.
`include "sorted_value_list_top_macros.svh"

module sorted_value_list_top #(
  parameter int CAPACITY = svl_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_operation,
  input  logic signed [svl_pkg::DATA_W-1:0] in_operand_value,
  output logic                             out_strobe,
  output logic [1:0]                       out_status,
  output logic signed [svl_pkg::DATA_W-1:0] out_removed_value,
  output logic [svl_pkg::OCC_W-1:0]        out_occupancy,
  output logic                             out_is_empty
);
  import svl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                     cmp_r, apply_r;
  logic [1:0]               op_r;
  logic signed [DATA_W-1:0] key_r;
  logic [CNT_W-1:0]         count_r, count_nxt;

  logic                     strobe_r;
  logic [1:0]               status_r, status_nxt;
  logic signed [DATA_W-1:0] removed_r, removed_nxt;
  logic [OCC_W-1:0]         occ_r;
  logic                     empty_r;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]      valid_vec, ge_vec, eq_vec;

  svl_bcast_t bc;
  logic       accept, found, full, empty, refused;

  assign accept = start && !busy;
  assign busy   = cmp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_r   <= 1'b0;
      apply_r <= 1'b0;
    end else begin
      cmp_r   <= accept;
      apply_r <= cmp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      key_r <= in_operand_value;
    end
  end

  assign found = |(eq_vec & valid_vec);
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    bc.cmp = cmp_r;
    bc.ins = apply_r && (op_r == OP_INSERT) && !full;
    bc.del = apply_r && (op_r == OP_DELETE) && found;
    bc.pop = apply_r && (op_r == OP_POP) && !empty;
    bc.key = key_r;
  end

  always_comb begin
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    removed_nxt = '0;
    case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_MISS;
        end
      end
      OP_POP: begin
        if (empty) begin
          status_nxt = ST_MISS;
        end else begin
          count_nxt   = count_r - CNT_W'(1);
          removed_nxt = cell_val[0];
        end
      end
      OP_SEARCH: begin
        if (!found) begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
        status_nxt = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= apply_r;
      if (apply_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_r) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      occ_r     <= OCC_W'(count_nxt);
      empty_r   <= (count_nxt == '0);
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_occupancy     = occ_r;
  assign out_is_empty      = empty_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] lv, rv;
    logic                     lvld, lge, rvld;

    if (g == 0) begin : g_head
      assign lv   = '0;
      assign lvld = 1'b0;
      assign lge  = 1'b0;
    end else begin : g_mid
      assign lv   = cell_val[g-1];
      assign lvld = valid_vec[g-1];
      assign lge  = ge_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_body
      assign rv   = cell_val[g+1];
      assign rvld = valid_vec[g+1];
    end

    svl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .bc          (bc),
      .left_val    (lv),
      .left_valid  (lvld),
      .left_ge     (lge),
      .right_val   (rv),
      .right_valid (rvld),
      .val         (cell_val[g]),
      .valid       (valid_vec[g]),
      .ge          (ge_vec[g]),
      .eq          (eq_vec[g])
    );
  end

  assign refused = out_strobe && (out_status == ST_FULL);

  // occupied cells always form a prefix of the row, one per stored word
  `SVL_ASSERT(a_fill_count, clk, rst_n, $countones(valid_vec) == count_r, "fill vs count")
  `SVL_NEVER(a_fill_gap, clk, rst_n, (valid_vec & (valid_vec + CAPACITY'(1))) != '0, "fill gap")
  `SVL_ASSERT(a_strobe_timing, clk, rst_n, out_strobe |-> $past(apply_r), "stray strobe")
  `SVL_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> busy, "busy missing")
  `SVL_ASSERT(a_full_refusal, clk, rst_n, refused |-> $past(full), "refused while not full")

endmodule
